// File: rtl/mgs_pkg.sv
// shared constants, types and state encodings for the mackey-glass series generator
// no dependencies; used by mgs_powdiv and mackey_glass_series_generator_unit
package mgs_pkg;

   localparam int MAX_DELAY_DEF     = 31;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int POWER_INT_BITS    = 20;

   localparam int          DELAY_W     = 5;
   localparam logic [4:0]  DELAY_RESET = 5'd17;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_X,
      ST_RD_D,
      ST_START,
      ST_CALC,
      ST_OUT
   } mgs_state_type;

   typedef enum logic [2:0] {
      UT_IDLE,
      UT_MUL,
      UT_FIN,
      UT_DEN,
      UT_DIV,
      UT_DONE
   } mgs_unit_state_type;

   typedef enum logic [1:0] {
      MUL_D2,
      MUL_D4,
      MUL_D8,
      MUL_D10
   } mgs_mul_idx_type;

   typedef struct packed {
      logic done;
      logic clip;
   } mgs_unit_stat_type;

endpackage

// File: rtl/mgs_powdiv.sv
// shared arithmetic unit: saturating d^10 on one partial-product multiplier,
// then restoring division d*2^F / (5*(2^F + d^10)); depends on mgs_pkg
module mgs_powdiv #(
   parameter int FRACTION_BITS = mgs_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [FRACTION_BITS+1:0]      d_in,
   output mgs_pkg::mgs_unit_stat_type    stat,
   output logic [FRACTION_BITS+1:0]      feedback
);

   localparam int F   = FRACTION_BITS;
   localparam int VB  = F + 2;
   localparam int IB  = mgs_pkg::POWER_INT_BITS;
   localparam int PW  = IB + F;
   localparam int AW  = PW + 2;
   localparam int LW  = (IB > F) ? IB : F;
   localparam int DW  = PW + 4;
   localparam int CW  = $clog2(VB);

   mgs_pkg::mgs_unit_state_type state_ff, state_in;
   mgs_pkg::mgs_mul_idx_type    mul_idx_ff;

   logic [PW-1:0]   op_a_ff, op_b_ff, d2_ff;
   logic [VB-1:0]   d_ff;
   logic [2:0]      step_ff;
   logic [AW-1:0]   acc_ff, term;
   logic            ovf_ff, clip_ff;
   logic [2*LW-1:0] prod_ff, prod_in;
   logic [LW-1:0]   mul_a, mul_b;
   logic [PW-1:0]   mul_res;
   logic            mul_clip;
   logic [DW-1:0]   den_ff, rem_ff;
   logic [PW:0]     den_sum;
   logic [DW:0]     rem_sh, rem_sub;
   logic            rem_ge;
   logic [VB-1:0]   num_ff, quo_ff;
   logic [CW-1:0]   cnt_ff;

   // partial product select: hi*hi, hi*lo, lo*hi, lo*lo
   always_comb begin
      unique case (step_ff)
         3'd0: begin
            mul_a = LW'(op_a_ff[PW-1:F]);
            mul_b = LW'(op_b_ff[PW-1:F]);
         end
         3'd1: begin
            mul_a = LW'(op_a_ff[PW-1:F]);
            mul_b = LW'(op_b_ff[F-1:0]);
         end
         3'd2: begin
            mul_a = LW'(op_a_ff[F-1:0]);
            mul_b = LW'(op_b_ff[PW-1:F]);
         end
         default: begin
            mul_a = LW'(op_a_ff[F-1:0]);
            mul_b = LW'(op_b_ff[F-1:0]);
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // align the previous partial product
   always_comb begin
      unique case (step_ff)
         3'd1:    term = AW'({prod_ff[IB-1:0], {F{1'b0}}});
         3'd2,
         3'd3:    term = AW'(prod_ff[PW-1:0]);
         3'd4:    term = AW'(prod_ff[2*F-1:F]);
         default: term = '0;
      endcase
   end

   assign mul_clip = ovf_ff || (acc_ff[AW-1:PW] != '0);
   assign mul_res  = mul_clip ? {PW{1'b1}} : acc_ff[PW-1:0];

   assign den_sum = (PW+1)'(op_a_ff) + ((PW+1)'(1) << F);
   assign rem_sh  = {rem_ff, num_ff[VB-1]};
   assign rem_ge  = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mgs_pkg::UT_IDLE: if (start) state_in = mgs_pkg::UT_MUL;
         mgs_pkg::UT_MUL:  if (step_ff == 3'd4) state_in = mgs_pkg::UT_FIN;
         mgs_pkg::UT_FIN: begin
            if (mul_idx_ff == mgs_pkg::MUL_D10) state_in = mgs_pkg::UT_DEN;
            else state_in = mgs_pkg::UT_MUL;
         end
         mgs_pkg::UT_DEN:  state_in = mgs_pkg::UT_DIV;
         mgs_pkg::UT_DIV:  if (cnt_ff == CW'(VB - 1)) state_in = mgs_pkg::UT_DONE;
         mgs_pkg::UT_DONE: state_in = mgs_pkg::UT_IDLE;
         default:          state_in = mgs_pkg::UT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      stat.done = (state_ff == mgs_pkg::UT_DONE);
      stat.clip = clip_ff;
      feedback  = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mgs_pkg::UT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         mgs_pkg::UT_IDLE: begin
            if (start) begin
               d_ff       <= d_in;
               op_a_ff    <= PW'(d_in);
               op_b_ff    <= PW'(d_in);
               clip_ff    <= 1'b0;
               mul_idx_ff <= mgs_pkg::MUL_D2;
               step_ff    <= 3'd0;
               acc_ff     <= '0;
               ovf_ff     <= 1'b0;
            end
         end
         mgs_pkg::UT_MUL: begin
            prod_ff <= prod_in;
            acc_ff  <= acc_ff + term;
            if (step_ff == 3'd1 && prod_ff[2*LW-1:IB] != '0) ovf_ff <= 1'b1;
            step_ff <= step_ff + 3'd1;
         end
         mgs_pkg::UT_FIN: begin
            clip_ff <= clip_ff | mul_clip;
            step_ff <= 3'd0;
            acc_ff  <= '0;
            ovf_ff  <= 1'b0;
            unique case (mul_idx_ff)
               mgs_pkg::MUL_D2: begin
                  d2_ff      <= mul_res;
                  op_a_ff    <= mul_res;
                  op_b_ff    <= mul_res;
                  mul_idx_ff <= mgs_pkg::MUL_D4;
               end
               mgs_pkg::MUL_D4: begin
                  op_a_ff    <= mul_res;
                  op_b_ff    <= mul_res;
                  mul_idx_ff <= mgs_pkg::MUL_D8;
               end
               mgs_pkg::MUL_D8: begin
                  op_a_ff    <= mul_res;
                  op_b_ff    <= d2_ff;
                  mul_idx_ff <= mgs_pkg::MUL_D10;
               end
               default: begin
                  op_a_ff    <= mul_res;
               end
            endcase
         end
         mgs_pkg::UT_DEN: begin
            den_ff <= DW'({den_sum, 2'b00}) + DW'(den_sum);
            rem_ff <= DW'(d_ff[VB-1:2]);
            num_ff <= {d_ff[1:0], {F{1'b0}}};
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         mgs_pkg::UT_DIV: begin
            rem_ff <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quo_ff <= {quo_ff[VB-2:0], rem_ge};
            num_ff <= {num_ff[VB-2:0], 1'b0};
            cnt_ff <= cnt_ff + CW'(1);
         end
         default: begin
         end
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == mgs_pkg::UT_IDLE)
      else $error("start while unit busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("done longer than one cycle");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == mgs_pkg::UT_DIV |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

endmodule

// File: rtl/mackey_glass_series_generator_unit.sv
// Mackey-Glass series generator. A load word (tuser 0) writes one history
// sample into the delay-line memory. A step word (tuser 1) reads x and the
// delayed d from the memory and runs d^10 and the feedback division on the
// shared mgs_powdiv unit, with four partial products per power and one
// quotient bit per cycle; one step at a time.
// A finished result waits in an output register while the next word is taken.
// Depends on mgs_pkg and mgs_powdiv.
module mackey_glass_series_generator_unit #(
   parameter int MAX_DELAY     = mgs_pkg::MAX_DELAY_DEF,
   parameter int FRACTION_BITS = mgs_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // history_value
   input  logic [((FRACTION_BITS+2+7)/8)*8-1:0]  req_tdata,
   // cmd
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // next_value
   output logic [((FRACTION_BITS+2+7)/8)*8-1:0]  rsp_tdata,
   // saturated
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mgs_pkg::DELAY_W-1:0]           csr_wdata
);

   localparam int F      = FRACTION_BITS;
   localparam int VB     = F + 2;
   localparam int DATA_W = ((VB + 7) / 8) * 8;
   localparam int DEPTH  = MAX_DELAY + 1;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int S10    = VB + 3;
   localparam logic [VB-1:0] DIV10_MUL = VB'((64'd1 << S10) / 64'd10);

   mgs_pkg::mgs_state_type state_ff, state_in;

   logic [mgs_pkg::DELAY_W-1:0] delay_ff;
   logic [IDX_W-1:0]  wp_ff, wp_in, cur_idx, old_idx, tau, rd_addr, wr_addr;
   logic [IDX_W:0]    old_wrap;
   logic [VB-1:0]     mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [VB-1:0]     rd_data_ff, rd_value, wr_data;
   logic              rd_vld_ff;
   logic              mem_we, accept, load_rsp, out_free, unit_start;

   logic [VB-1:0]     x_ff, decay_ff, fb;
   logic [2*VB-1:0]   xm_ff;
   logic [VB-4:0]     q0;
   logic [VB:0]       rem10;
   logic [VB:0]       sum;
   logic              sum_sat;
   logic [VB-1:0]     next_value;

   logic              rsp_valid_ff;
   logic [VB-1:0]     rsp_value_ff;
   logic              rsp_sat_ff;

   mgs_pkg::mgs_unit_stat_type stat;

   mgs_powdiv #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_powdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .d_in     (rd_value),
      .stat     (stat),
      .feedback (fb)
   );

   // csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= mgs_pkg::DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         delay_ff <= csr_wdata;
      end
   end

   // delay-line addressing
   always_comb begin
      if (delay_ff == '0) tau = IDX_W'(1);
      else if (int'(delay_ff) > MAX_DELAY) tau = IDX_W'(MAX_DELAY);
      else tau = IDX_W'(delay_ff);
      cur_idx  = (wp_ff == '0) ? IDX_W'(MAX_DELAY) : wp_ff - IDX_W'(1);
      old_wrap = {1'b0, cur_idx} + (IDX_W+1)'(DEPTH) - {1'b0, tau};
      old_idx  = (cur_idx >= tau) ? cur_idx - tau : old_wrap[IDX_W-1:0];
      wp_in    = (wp_ff == IDX_W'(MAX_DELAY)) ? '0 : wp_ff + IDX_W'(1);
      rd_addr  = (state_ff == mgs_pkg::ST_RD_X) ? cur_idx : old_idx;
      wr_addr  = wp_ff;
      wr_data  = (state_ff == mgs_pkg::ST_OUT) ? next_value : req_tdata[VB-1:0];
      rd_value = rd_vld_ff ? rd_data_ff : '0;
   end

   // delay-line memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         wp_ff     <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (mem_we) begin
            vld_ff[wr_addr] <= 1'b1;
            wp_ff           <= wp_in;
         end
      end
   end

   // decay term floor(x/10) by reciprocal multiply and one correction
   assign q0    = xm_ff[2*VB-1:S10];
   assign rem10 = (VB+1)'(x_ff) - (((VB+1)'(q0) << 3) + ((VB+1)'(q0) << 1));

   always_ff @(posedge clock) begin
      if (state_ff == mgs_pkg::ST_RD_D) x_ff <= rd_value;
      xm_ff    <= x_ff * DIV10_MUL;
      decay_ff <= VB'(q0) + VB'(rem10 >= (VB+1)'(10));
   end

   assign sum        = (VB+1)'(x_ff) - (VB+1)'(decay_ff) + (VB+1)'(fb);
   assign sum_sat    = sum[VB];
   assign next_value = sum_sat ? {VB{1'b1}} : sum[VB-1:0];

   // control
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mgs_pkg::ST_IDLE: begin
            if (accept && req_tuser == mgs_pkg::CMD_STEP) state_in = mgs_pkg::ST_RD_X;
         end
         mgs_pkg::ST_RD_X:  state_in = mgs_pkg::ST_RD_D;
         mgs_pkg::ST_RD_D:  state_in = mgs_pkg::ST_START;
         mgs_pkg::ST_START: state_in = mgs_pkg::ST_CALC;
         mgs_pkg::ST_CALC:  if (stat.done) state_in = mgs_pkg::ST_OUT;
         mgs_pkg::ST_OUT:   if (out_free) state_in = mgs_pkg::ST_IDLE;
         default:           state_in = mgs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == mgs_pkg::ST_IDLE);
      unit_start = (state_ff == mgs_pkg::ST_START);
      load_rsp   = (state_ff == mgs_pkg::ST_OUT) && out_free;
      mem_we     = load_rsp ||
                   (accept && req_tuser == mgs_pkg::CMD_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mgs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff <= next_value;
         rsp_sat_ff   <= stat.clip | sum_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_sat_ff;

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      int'(wp_ff) <= MAX_DELAY)
      else $error("write pointer out of range");

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      ($past(mem_we) && !$past(reset)) |->
         wp_ff == (($past(wp_ff) == IDX_W'(MAX_DELAY)) ? '0 : $past(wp_ff) + IDX_W'(1)))
      else $error("write pointer did not advance on write");

   a_step_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == mgs_pkg::CMD_STEP) |=> state_ff == mgs_pkg::ST_RD_X)
      else $error("step word did not start a read");

endmodule

// File: tb/mgs_series_checker.sv
// checker for the mackey-glass series generator: watches the word, result and csr channels,
// predicts each step result from its own delay-line model and compares field by field
// depends on mgs_pkg; instantiated beside the block by mackey_glass_series_generator_unit_test
module mgs_series_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [23:0]                 req_tdata,
   input  logic                        req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [23:0]                 rsp_tdata,
   input  logic                        rsp_tuser,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [mgs_pkg::DELAY_W-1:0] csr_wdata,
   output int                          error_count,
   output int                          pending_count
);

   localparam int FRAC      = mgs_pkg::FRACTION_BITS_DEF;
   localparam int POW_INT   = mgs_pkg::POWER_INT_BITS;
   localparam int MAX_TAU   = mgs_pkg::MAX_DELAY_DEF;
   localparam int DEPTH     = MAX_TAU + 1;
   localparam int VALUE_W   = FRAC + 2;
   localparam logic [63:0] VALUE_LIMIT = (64'd1 << VALUE_W) - 64'd1;
   localparam logic [63:0] FRAC_MASK   = (64'd1 << FRAC) - 64'd1;
   localparam logic [63:0] POW_LIMIT   = (64'd1 << (POW_INT + FRAC)) - 64'd1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               clipped;
   } series_point_type;

   logic [VALUE_W-1:0]          series_line [DEPTH];
   int                          write_slot;
   logic [mgs_pkg::DELAY_W-1:0] delay_reg;
   series_point_type            expected_points[$];

   task automatic flag_error(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   function automatic logic [63:0] power_product(input logic [63:0] a, input logic [63:0] b,
                                                 inout logic clipped);
      logic [63:0] ah, al, bh, bl, whole, sum;
      ah = a >> FRAC;
      al = a & FRAC_MASK;
      bh = b >> FRAC;
      bl = b & FRAC_MASK;
      whole = ah * bh;
      if (whole >= (64'd1 << POW_INT)) begin
         clipped = 1'b1;
         return POW_LIMIT;
      end
      sum = (whole << FRAC) + ah * bl + al * bh + ((al * bl) >> FRAC);
      if (sum > POW_LIMIT) begin
         clipped = 1'b1;
         return POW_LIMIT;
      end
      return sum;
   endfunction

   task automatic push_series(input logic [VALUE_W-1:0] value);
      series_line[write_slot] = value;
      write_slot = (write_slot + 1) % DEPTH;
   endtask

   task automatic predict_step();
      int               tau;
      logic [63:0]      x, d, d2, d4, d8, d10, feedback, next;
      logic             clipped;
      series_point_type point;
      tau = delay_reg;
      if (tau < 1) tau = 1;
      if (tau > MAX_TAU) tau = MAX_TAU;
      clipped = 1'b0;
      x = 64'(series_line[(write_slot + DEPTH - 1) % DEPTH]);
      d = 64'(series_line[(write_slot + 2 * DEPTH - 1 - tau) % DEPTH]);
      d2 = power_product(d, d, clipped);
      d4 = power_product(d2, d2, clipped);
      d8 = power_product(d4, d4, clipped);
      d10 = power_product(d8, d2, clipped);
      feedback = (d << FRAC) / (64'd5 * ((64'd1 << FRAC) + d10));
      next = x - x / 64'd10 + feedback;
      if (next > VALUE_LIMIT) begin
         next = VALUE_LIMIT;
         clipped = 1'b1;
      end
      push_series(next[VALUE_W-1:0]);
      point.value = next[VALUE_W-1:0];
      point.clipped = clipped;
      expected_points.push_back(point);
   endtask

   task automatic check_result();
      series_point_type want;
      if (expected_points.size() == 0) begin
         flag_error($sformatf("result word %h with no step pending", rsp_tdata));
         return;
      end
      want = expected_points.pop_front();
      if (rsp_tdata[VALUE_W-1:0] !== want.value)
         flag_error($sformatf("next_value %h, predicted %h", rsp_tdata[VALUE_W-1:0],
                              want.value));
      if ((rsp_tdata >> VALUE_W) !== '0)
         flag_error($sformatf("tdata padding not zero: %h", rsp_tdata));
      if (rsp_tuser !== want.clipped)
         flag_error($sformatf("saturated %b, predicted %b", rsp_tuser, want.clipped));
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) series_line[i] = '0;
         write_slot = 0;
         delay_reg = mgs_pkg::DELAY_RESET;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) delay_reg = csr_wdata;
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) begin
            if (req_tuser == mgs_pkg::CMD_STEP) predict_step();
            else push_series(req_tdata[VALUE_W-1:0]);
         end
      end
      pending_count = expected_points.size();
   end

endmodule

// File: tb/mackey_glass_series_generator_unit_test.sv
// top of the mackey-glass series generator testbench: clock, reset, history and step words,
// delay settings and receiver stalls; the verdict comes from the failure count of the checker
// depends on mgs_pkg, mgs_series_checker and mackey_glass_series_generator_unit
module mackey_glass_series_generator_unit_test;

   localparam int VALUE_W    = mgs_pkg::FRACTION_BITS_DEF + 2;
   localparam int DATA_W     = ((VALUE_W + 7) / 8) * 8;
   localparam int STEP_WAIT  = 80;
   localparam int HOLD_LEN   = 400;
   localparam int CYCLE_CAP  = 1000000;
   localparam logic [VALUE_W-1:0] VALUE_TOP = '1;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [DATA_W-1:0]           req_tdata;   // history_value
   logic                        req_tuser;   // cmd
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [DATA_W-1:0]           rsp_tdata;   // next_value
   logic                        rsp_tuser;   // saturated
   logic                        csr_valid;
   logic                        csr_ready;
   logic [mgs_pkg::DELAY_W-1:0] csr_wdata;

   int error_count;
   int pending_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_req;
   int cycles;

   mackey_glass_series_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   mgs_series_checker checker_unit (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_CAP) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // receiver side, with one long hold-off on request
   initial begin
      int  hold_left;
      bit  hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99, 0) >= receiver_stall_pct);
         end
      end
   end

   task automatic send_word(input logic cmd, input logic [VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = DATA_W'(value);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_history(input logic [VALUE_W-1:0] value);
      send_word(mgs_pkg::CMD_LOAD, value);
   endtask

   task automatic step_series();
      send_word(mgs_pkg::CMD_STEP, VALUE_W'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (STEP_WAIT) @(posedge clock);
   endtask

   task automatic write_delay(input logic [mgs_pkg::DELAY_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] pick_history();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) return VALUE_W'($urandom_range(91750, 13107));
      if (roll < 85) return VALUE_W'($urandom);
      return (roll < 92) ? '0 : VALUE_TOP;
   endfunction

   initial begin
      logic [mgs_pkg::DELAY_W-1:0] phase_delay [6];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = mgs_pkg::CMD_LOAD;
      csr_valid = 1'b0;
      csr_wdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_req = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // empty history at the reset delay
      step_series();
      step_series();
      wait_drained();

      write_delay(5'd1);
      load_history(VALUE_TOP);
      load_history(18'd100);
      step_series();
      step_series();
      load_history('0);
      load_history(18'd65536);
      step_series();
      load_history(18'd51773);
      load_history(18'd200000);
      step_series();
      load_history(18'h2AAAA);
      load_history(18'h15555);
      step_series();
      load_history(VALUE_TOP);
      load_history(VALUE_TOP);
      step_series();
      step_series();
      wait_drained();

      phase_delay[0] = 5'd31;
      phase_delay[1] = 5'd0;
      phase_delay[2] = 5'd1;
      phase_delay[3] = 5'($urandom_range(30, 2));
      phase_delay[4] = 5'd17;
      phase_delay[5] = 5'($urandom_range(31, 0));
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         write_delay(phase_delay[phase]);
         for (int i = 0; i < 32; i++) load_history(pick_history());
         if (phase == 4) hold_req = 1'b1;
         for (int i = 0; i < 170; i++) begin
            if ($urandom_range(99, 0) < 65) step_series();
            else load_history(pick_history());
         end
         wait_drained();
      end

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
rtl/mgs_pkg.sv
rtl/mgs_powdiv.sv
rtl/mackey_glass_series_generator_unit.sv
tb/mgs_series_checker.sv
tb/mackey_glass_series_generator_unit_test.sv
